FILE: sv/fqrr_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the four-queue round-robin merge unit.
// No dependencies; every other file but fqrr_ram imports this package.
package fqrr_pkg;

    localparam int NUM_QUEUES = 4;
    localparam int SLOTS      = 16;
    localparam int QIDX_W     = 2;
    localparam int SLOT_W     = 4;
    localparam int ADDR_W     = QIDX_W + SLOT_W;
    localparam int STORE_D    = NUM_QUEUES * SLOTS;
    localparam int CNT_W      = 5;
    localparam int TOTAL_W    = 7;
    localparam int MODE_W     = 2;
    localparam int CODE_W     = 3;
    localparam int TAG_W      = 64;

    typedef logic [MODE_W-1:0] t_mode;
    typedef logic [CODE_W-1:0] t_code;
    typedef logic [TAG_W-1:0]  t_tag;

    localparam t_mode MODE_SELECT = 2'd0;
    localparam t_mode MODE_PUSH   = 2'd1;
    localparam t_mode MODE_DRAIN  = 2'd2;

    localparam t_code CODE_NONE  = 3'd0;
    localparam t_code CODE_FIRST = 3'd1;
    localparam t_code CODE_LAST  = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LOAD,
        ST_SEND
    } t_state;

    // Request to the queue pointer unit
    typedef struct packed {
        logic              push;
        logic              pop;
        logic              clear;
        logic [QIDX_W-1:0] qidx;
    } t_ptr_op;

    // Status of the queue addressed by the request
    typedef struct packed {
        logic [SLOT_W-1:0] tail;
        logic [SLOT_W-1:0] head;
        logic              full;
        logic              empty;
    } t_ptr_stat;

    // Visit order within a round: queues 1, 3, 2, 4
    function automatic logic [QIDX_W-1:0] visit_qidx(input logic [QIDX_W-1:0] pos);
        logic [QIDX_W-1:0] q;
        case (pos)
            2'd0:    q = 2'd0;
            2'd1:    q = 2'd2;
            2'd2:    q = 2'd1;
            default: q = 2'd3;
        endcase
        return q;
    endfunction

endpackage

FILE: sv/fqrr_in_if.sv
`timescale 1ns / 1ps
// Input channel: valid/ready handshake carrying one command beat.
// Depends on fqrr_pkg.
interface fqrr_in_if;
    import fqrr_pkg::*;

    logic  valid;
    logic  ready;
    t_mode mode;
    t_code queue_code;
    t_tag  tag;

    modport source (output valid, output mode, output queue_code, output tag, input ready);
    modport sink   (input valid, input mode, input queue_code, input tag, output ready);
endinterface

FILE: sv/fqrr_out_if.sv
`timescale 1ns / 1ps
// Output channel: valid/ready handshake carrying one drained result beat.
// Depends on fqrr_pkg.
interface fqrr_out_if;
    import fqrr_pkg::*;

    logic  valid;
    logic  ready;
    logic  valid_res;
    t_tag  out_tag;
    t_code source_queue;
    logic  overflow;
    logic  last;

    modport source (output valid, output valid_res, output out_tag, output source_queue,
                    output overflow, output last, input ready);
    modport sink   (input valid, input valid_res, input out_tag, input source_queue,
                    input overflow, input last, output ready);
endinterface

FILE: sv/fqrr_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fqrr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: sv/fqrr_ptrs.sv
`timescale 1ns / 1ps
// Per-queue occupancy and read pointers, updated through one shared port.
// Depends on fqrr_pkg.
module fqrr_ptrs #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fqrr_pkg::t_ptr_op   i_op,
    output fqrr_pkg::t_ptr_stat o_stat
);
    import fqrr_pkg::*;

    localparam logic [CNT_W-1:0]  DEPTH_C   = CNT_W'(QUEUE_DEPTH);
    localparam logic [SLOT_W-1:0] HEAD_WRAP = SLOT_W'(QUEUE_DEPTH - 1);

    logic [CNT_W-1:0]  r_count [NUM_QUEUES];
    logic [SLOT_W-1:0] r_head  [NUM_QUEUES];
    logic [CNT_W-1:0]  w_cnt;
    logic [SLOT_W-1:0] w_head;

    assign w_cnt  = r_count[i_op.qidx];
    assign w_head = r_head[i_op.qidx];

    always_comb begin
        o_stat.tail  = w_cnt[SLOT_W-1:0];
        o_stat.head  = w_head;
        o_stat.full  = (w_cnt >= DEPTH_C);
        o_stat.empty = (w_cnt == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_op.clear) begin
            for (int i = 0; i < NUM_QUEUES; i++) begin
                r_count[i] <= '0;
                r_head[i]  <= '0;
            end
        end else if (i_op.push && !o_stat.full) begin
            r_count[i_op.qidx] <= w_cnt + CNT_W'(1);
        end else if (i_op.pop) begin
            r_count[i_op.qidx] <= w_cnt - CNT_W'(1);
            r_head[i_op.qidx]  <= (w_head == HEAD_WRAP) ? '0 : w_head + SLOT_W'(1);
        end
    end
endmodule

FILE: sv/four_queue_round_robin_merge_unit.sv
`timescale 1ns / 1ps
// Four tag queues merged in round-robin order (queues 1, 3, 2, 4) on a drain.
// Select and push beats are taken while idle. A drain moves each tag through
// the scan, RAM read and send states, as the pointer port is shared and the
// tag RAM read is registered, and skips empty queues in the scan state; input
// is held off until its last result beat is taken. Synchronous active-low
// reset empties all queues, clears the selection and the overflow flag; the
// tag store is not cleared.
module four_queue_round_robin_merge_unit #(
    parameter int QUEUE_DEPTH = 16,
    parameter int TAG_BITS    = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fqrr_in_if.sink    i_in,
    fqrr_out_if.source o_out
);
    import fqrr_pkg::*;

    t_state              r_state, n_state;
    t_code               r_cur;
    logic                r_ovf;
    logic [TOTAL_W-1:0]  r_total;
    logic [QIDX_W-1:0]   r_vis;
    logic                r_res_valid;
    t_code               r_src;
    logic                r_last;
    t_tag                r_tag;

    t_ptr_op             w_op;
    t_ptr_stat           w_stat;
    logic [QIDX_W-1:0]   w_cur_q;
    logic [QIDX_W-1:0]   w_vis_q;
    logic                w_in_fire;
    logic                w_out_fire;
    logic                w_push_ok;
    logic                w_we;
    logic                w_re;
    logic [ADDR_W-1:0]   w_waddr;
    logic [ADDR_W-1:0]   w_raddr;
    logic [TAG_BITS-1:0] w_rdata;

    assign w_cur_q    = QIDX_W'(r_cur - CODE_FIRST);
    assign w_vis_q    = visit_qidx(r_vis);
    assign w_in_fire  = i_in.valid && i_in.ready;
    assign w_out_fire = o_out.valid && o_out.ready;
    assign w_push_ok  = w_in_fire && (i_in.mode == MODE_PUSH) && (r_cur != CODE_NONE);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_fire && i_in.mode == MODE_DRAIN) begin
                    n_state = (r_total == '0) ? ST_SEND : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (!w_stat.empty) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: n_state = ST_SEND;
            ST_SEND: begin
                if (w_out_fire) begin
                    n_state = r_last ? ST_IDLE : ST_SCAN;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb begin
        i_in.ready  = 1'b0;
        o_out.valid = 1'b0;
        w_op        = '0;
        w_op.qidx   = w_cur_q;
        w_we        = 1'b0;
        w_re        = 1'b0;
        case (r_state)
            ST_IDLE: begin
                i_in.ready = 1'b1;
                w_op.push  = w_push_ok;
                w_we       = w_push_ok && !w_stat.full;
            end
            ST_SCAN: begin
                w_op.qidx = w_vis_q;
                w_op.pop  = !w_stat.empty;
                w_re      = !w_stat.empty;
            end
            ST_LOAD: w_op.qidx = w_vis_q;
            ST_SEND: begin
                o_out.valid = 1'b1;
                w_op.clear  = w_out_fire && r_last;
            end
            default: ;
        endcase
    end

    assign w_waddr = {w_cur_q, w_stat.tail};
    assign w_raddr = {w_vis_q, w_stat.head};

    fqrr_ptrs #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_ptrs (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_op   (w_op),
        .o_stat (w_stat)
    );

    fqrr_ram #(
        .WIDTH(TAG_BITS),
        .DEPTH(STORE_D)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(i_in.tag[TAG_BITS-1:0]),
        .i_re   (w_re),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cur   <= CODE_NONE;
            r_ovf   <= 1'b0;
            r_total <= '0;
            r_vis   <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                ST_IDLE: begin
                    if (w_in_fire && i_in.mode == MODE_SELECT) begin
                        r_cur <= (i_in.queue_code inside {[CODE_FIRST:CODE_LAST]})
                                 ? i_in.queue_code : CODE_NONE;
                    end
                    if (w_push_ok) begin
                        if (w_stat.full) begin
                            r_ovf <= 1'b1;
                        end else begin
                            r_total <= r_total + TOTAL_W'(1);
                        end
                    end
                    if (w_in_fire && i_in.mode == MODE_DRAIN) begin
                        r_vis <= '0;
                    end
                end
                ST_SCAN: begin
                    if (w_stat.empty) begin
                        r_vis <= r_vis + QIDX_W'(1);
                    end else begin
                        r_total <= r_total - TOTAL_W'(1);
                    end
                end
                ST_SEND: begin
                    if (w_out_fire) begin
                        if (r_last) begin
                            r_cur <= CODE_NONE;
                            r_ovf <= 1'b0;
                        end else begin
                            r_vis <= r_vis + QIDX_W'(1);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Result payload: hold until the beat is taken
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (w_in_fire && i_in.mode == MODE_DRAIN) begin
                    r_res_valid <= 1'b0;
                    r_tag       <= '0;
                    r_src       <= CODE_NONE;
                    r_last      <= 1'b1;
                end
            end
            ST_SCAN: begin
                if (!w_stat.empty) begin
                    r_src  <= CODE_W'(w_vis_q) + CODE_FIRST;
                    r_last <= (r_total == TOTAL_W'(1));
                end
            end
            ST_LOAD: begin
                r_res_valid <= 1'b1;
                r_tag       <= TAG_W'(w_rdata);
            end
            default: ;
        endcase
    end

    assign o_out.valid_res    = r_res_valid;
    assign o_out.out_tag      = r_tag;
    assign o_out.source_queue = r_src;
    assign o_out.overflow     = r_ovf;
    assign o_out.last         = r_last;
endmodule
